/* hdl/ptt_pkg.sv */
// Shared types, codes and helpers of the periodic timer table.
package ptt_pkg;

    localparam int PTT_CAPACITY = 16;

    localparam int TIME_W   = 63;
    localparam int PERIOD_W = 32;
    localparam int HANDLE_W = 16;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 3;
    localparam int REQ_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 2'd0,
        REQ_RESTART = 2'd1,
        REQ_KILL    = 2'd2,
        REQ_CHECK   = 2'd3
    } t_req;

    typedef enum logic [KIND_W-1:0] {
        K_ASSIGNED = 3'd0,
        K_FULL     = 3'd1,
        K_ACK      = 3'd2,
        K_BAD      = 3'd3,
        K_RELOC    = 3'd4,
        K_FIRED    = 3'd5,
        K_DONE     = 3'd6
    } t_kind;

    typedef struct packed {
        logic [TIME_W-1:0]   due;
        logic                dead;
        logic [PERIOD_W-1:0] per;
        logic [HANDLE_W-1:0] hnd;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        RD_SLOT  = 3'd0,
        RD_I     = 3'd1,
        RD_BACK  = 3'd2,
        RD_INEXT = 3'd3,
        RD_ZERO  = 3'd4
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NEW     = 3'd0,
        WR_RESTART = 3'd1,
        WR_KILL    = 3'd2,
        WR_MOVE    = 3'd3,
        WR_FIRE    = 3'd4
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    i_clr;
        logic    i_inc;
        logic    end_dec;
        logic    live_inc;
        logic    live_commit;
        logic    we;
        t_wr_sel wr_sel;
        t_rd_sel rd_sel;
        logic    emit;
        t_kind   kind;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic full;
        logic bad_slot;
        logic q_dead;
        logic back_eq_i;
        logic i1_lt_end;
        logic end_zero;
        logic due_hit;
    } t_sts;

    // Time sums never wrap in 64 bits, so bit 63 alone flags saturation.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                  input logic [PERIOD_W-1:0] p);
        logic [TIME_W:0] s;
        s = {1'b0, t} + (TIME_W+1)'(p);
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

/* hdl/periodic_timer_table.sv */
// Top level of the periodic timer table: sequencer plus datapath.
//
// A request is one beat: it is taken at a rising edge with start high and
// busy low. req_type selects start, restart, kill or check; the other
// fields carry handle, slot, period and the current time.
// Results leave as beats on o_kind/o_handle/o_slot_out/o_last, each valid
// for exactly one cycle while o_strobe is high; o_last marks the final beat
// of a request. The receiver cannot stall, so every beat must be taken.
// A start, or a request with a bad slot, gives its beat from the dispatch
// state; restart and kill first read the entry back and give theirs when
// they write it. A check walks the table in the entry RAM after dispatch:
// a live slot is kept, a dead entry is replaced by the last one (read it,
// then write it into the hole) and a dead entry at the end is dropped off;
// after a turn the firing pass visits each live slot, then the done beat
// follows. busy drops the cycle the last beat is registered, so a new
// request may follow immediately.
// Synchronous reset empties the table; entry contents are not cleared and
// need not be, since only the contents of occupied slots are ever used.
module periodic_timer_table #(
    parameter int CAPACITY = ptt_pkg::PTT_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ptt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [ptt_pkg::HANDLE_W-1:0]  i_timer_handle,
    input  logic [ptt_pkg::SLOT_W-1:0]    i_slot,
    input  logic [ptt_pkg::PERIOD_W-1:0]  i_period_ms,
    input  logic [ptt_pkg::TIME_W-1:0]    i_now_ms,
    output logic                          o_strobe,
    output logic [ptt_pkg::KIND_W-1:0]    o_kind,
    output logic [ptt_pkg::HANDLE_W-1:0]  o_handle,
    output logic [ptt_pkg::SLOT_W-1:0]    o_slot_out,
    output logic                          o_last
);
    import ptt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ptt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ptt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_timer_handle (i_timer_handle),
        .i_slot         (i_slot),
        .i_period_ms    (i_period_ms),
        .i_now_ms       (i_now_ms),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_handle       (o_handle),
        .o_slot_out     (o_slot_out),
        .o_last         (o_last)
    );

endmodule

/* hdl/ptt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered, write-first read.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_we && (i_wr_addr == i_rd_addr)) begin
            r_q <= i_wr_data;
        end else begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

/* hdl/ptt_ctrl.sv */
// Sequencer of the timer table: decodes requests and steps the slot walks.
module ptt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ptt_pkg::t_sts i_sts,
    output ptt_pkg::t_cmd o_cmd
);
    import ptt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_RMW      = 8'b0000_0100,
        S_CEVAL    = 8'b0000_1000,
        S_CMOVE    = 8'b0001_0000,
        S_FSTART   = 8'b0010_0000,
        S_FEVAL    = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        cmd.wr_sel  = WR_NEW;
        cmd.rd_sel  = RD_I;
        cmd.kind    = K_DONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.req)
                    REQ_START: begin
                        cmd.emit = 1'b1;
                        if (i_sts.full) begin
                            cmd.kind = K_FULL;
                        end else begin
                            cmd.kind     = K_ASSIGNED;
                            cmd.we       = 1'b1;
                            cmd.wr_sel   = WR_NEW;
                            cmd.live_inc = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                    REQ_RESTART, REQ_KILL: begin
                        if (i_sts.bad_slot) begin
                            cmd.emit = 1'b1;
                            cmd.kind = K_BAD;
                            n_state  = S_IDLE;
                        end else begin
                            cmd.rd_sel = RD_SLOT;
                            n_state    = S_RMW;
                        end
                    end
                    default: begin
                        cmd.rd_sel = RD_I;
                        n_state    = i_sts.end_zero ? S_FSTART : S_CEVAL;
                    end
                endcase
            end
            S_RMW: begin
                cmd.we     = 1'b1;
                cmd.wr_sel = (i_sts.req == REQ_RESTART) ? WR_RESTART : WR_KILL;
                cmd.emit   = 1'b1;
                cmd.kind   = K_ACK;
                n_state    = S_IDLE;
            end
            S_CEVAL: begin
                if (i_sts.q_dead) begin
                    if (i_sts.back_eq_i) begin
                        // The hole is the last entry: it just drops off the end.
                        cmd.end_dec = 1'b1;
                        n_state     = S_FSTART;
                    end else begin
                        cmd.rd_sel = RD_BACK;
                        n_state    = S_CMOVE;
                    end
                end else if (i_sts.i1_lt_end) begin
                    cmd.i_inc  = 1'b1;
                    cmd.rd_sel = RD_INEXT;
                end else begin
                    n_state = S_FSTART;
                end
            end
            S_CMOVE: begin
                // The moved entry lands in the hole and is looked at again.
                cmd.we      = 1'b1;
                cmd.wr_sel  = WR_MOVE;
                cmd.emit    = 1'b1;
                cmd.kind    = K_RELOC;
                cmd.end_dec = 1'b1;
                cmd.rd_sel  = RD_I;
                n_state     = S_CEVAL;
            end
            S_FSTART: begin
                cmd.live_commit = 1'b1;
                cmd.i_clr       = 1'b1;
                cmd.rd_sel      = RD_ZERO;
                n_state         = i_sts.end_zero ? S_DONE : S_FEVAL;
            end
            S_FEVAL: begin
                if (i_sts.due_hit) begin
                    cmd.we     = 1'b1;
                    cmd.wr_sel = WR_FIRE;
                    cmd.emit   = 1'b1;
                    cmd.kind   = K_FIRED;
                end
                if (i_sts.i1_lt_end) begin
                    cmd.i_inc  = 1'b1;
                    cmd.rd_sel = RD_INEXT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                cmd.emit = 1'b1;
                cmd.kind = K_DONE;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = cmd;

endmodule

/* hdl/ptt_dp.sv */
// Datapath of the timer table: request latch, walk counters, entry RAM and result register.
module ptt_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ptt_pkg::REQ_W-1:0]      i_req_type,
    input  logic [ptt_pkg::HANDLE_W-1:0]   i_timer_handle,
    input  logic [ptt_pkg::SLOT_W-1:0]     i_slot,
    input  logic [ptt_pkg::PERIOD_W-1:0]   i_period_ms,
    input  logic [ptt_pkg::TIME_W-1:0]     i_now_ms,
    input  ptt_pkg::t_cmd                  i_cmd,
    output ptt_pkg::t_sts                  o_sts,
    output logic                           o_strobe,
    output logic [ptt_pkg::KIND_W-1:0]     o_kind,
    output logic [ptt_pkg::HANDLE_W-1:0]   o_handle,
    output logic [ptt_pkg::SLOT_W-1:0]     o_slot_out,
    output logic                           o_last
);
    import ptt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int SW = (LW > SLOT_W) ? LW : SLOT_W;

    t_req                r_req;
    logic [HANDLE_W-1:0] r_hnd;
    logic [SLOT_W-1:0]   r_slot;
    logic [PERIOD_W-1:0] r_per;
    logic [TIME_W-1:0]   r_now;
    logic [LW-1:0]       r_live;
    logic [LW-1:0]       r_end;
    logic [AW-1:0]       r_i;

    logic                r_strobe;
    t_kind               r_kind;
    logic [HANDLE_W-1:0] r_ohnd;
    logic [SLOT_W-1:0]   r_oslot;
    logic                r_last;

    t_entry              q;
    logic [ENTRY_W-1:0]  rd_data;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    logic [AW-1:0]       back_idx;
    logic [TIME_W-1:0]   add_a;
    logic [PERIOD_W-1:0] add_b;
    logic [TIME_W-1:0]   add_sum;

    assign q        = t_entry'(rd_data);
    assign back_idx = AW'(r_end - 1'b1);

    // One saturating adder serves new due times and periodic advances.
    assign add_a   = (i_cmd.wr_sel == WR_FIRE) ? q.due : r_now;
    assign add_b   = (i_cmd.wr_sel == WR_FIRE) ? q.per : r_per;
    assign add_sum = sat_add(add_a, add_b);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_SLOT:  rd_addr = AW'(r_slot);
            RD_I:     rd_addr = r_i;
            RD_BACK:  rd_addr = back_idx;
            RD_INEXT: rd_addr = r_i + 1'b1;
            default:  rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_addr = r_i;
        wr_data = q;
        case (i_cmd.wr_sel)
            WR_NEW: begin
                wr_addr = AW'(r_live);
                wr_data = '{due: add_sum, dead: 1'b0, per: r_per, hnd: r_hnd};
            end
            WR_RESTART: begin
                wr_addr = AW'(r_slot);
                wr_data = '{due: add_sum, dead: 1'b0, per: r_per, hnd: q.hnd};
            end
            WR_KILL: begin
                wr_addr      = AW'(r_slot);
                wr_data      = q;
                wr_data.dead = 1'b1;
            end
            WR_MOVE: begin
                wr_addr = r_i;
                wr_data = q;
            end
            WR_FIRE: begin
                wr_addr     = r_i;
                wr_data     = q;
                wr_data.due = add_sum;
            end
            default: begin
                wr_addr = r_i;
                wr_data = q;
            end
        endcase
    end

    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= t_req'(i_req_type);
            r_hnd  <= i_timer_handle;
            r_slot <= i_slot;
            r_per  <= i_period_ms;
            r_now  <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
            r_end  <= '0;
            r_i    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_end <= r_live;
            end else if (i_cmd.end_dec) begin
                r_end <= r_end - 1'b1;
            end
            if (i_cmd.load || i_cmd.i_clr) begin
                r_i <= '0;
            end else if (i_cmd.i_inc) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.live_inc) begin
                r_live <= r_live + 1'b1;
            end else if (i_cmd.live_commit) begin
                r_live <= r_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= i_cmd.kind;
            r_last <= (i_cmd.kind != K_RELOC) && (i_cmd.kind != K_FIRED);
            case (i_cmd.kind)
                K_ASSIGNED: begin
                    r_ohnd  <= r_hnd;
                    r_oslot <= SLOT_W'(r_live);
                end
                K_ACK, K_BAD: begin
                    r_ohnd  <= '0;
                    r_oslot <= r_slot;
                end
                K_RELOC, K_FIRED: begin
                    r_ohnd  <= q.hnd;
                    r_oslot <= SLOT_W'(r_i);
                end
                default: begin
                    r_ohnd  <= '0;
                    r_oslot <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.req       = r_req;
        o_sts.full      = (r_live == LW'(CAPACITY));
        o_sts.bad_slot  = (SW'(r_slot) >= SW'(r_live));
        o_sts.q_dead    = q.dead;
        o_sts.back_eq_i = (back_idx == r_i);
        o_sts.i1_lt_end = ((LW'(r_i) + 1'b1) < r_end);
        o_sts.end_zero  = (r_end == '0);
        o_sts.due_hit   = (r_now >= q.due);
    end

    assign o_strobe   = r_strobe;
    assign o_kind     = r_kind;
    assign o_handle   = r_ohnd;
    assign o_slot_out = r_oslot;
    assign o_last     = r_last;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LW'(CAPACITY))
        else $error("live count above capacity");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.we && (i_cmd.wr_sel == WR_MOVE || i_cmd.wr_sel == WR_FIRE)
        |-> (LW'(r_i) < r_end))
        else $error("walk write outside the occupied slots");

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.we && (i_cmd.wr_sel == WR_NEW) |-> (r_live < LW'(CAPACITY)))
        else $error("append into a full table");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("result beat right after the final beat of a request");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench of the periodic timer table: directed table, random requests.
module tb;
    import ptt_pkg::*;

    localparam int               CAP    = PTT_CAPACITY;
    localparam logic [TIME_W-1:0] TOP_MS = {TIME_W{1'b1}};

    typedef struct packed {
        t_kind               kind;
        logic [HANDLE_W-1:0] hnd;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } t_beat;

    typedef struct packed {
        t_req                rq;
        logic [HANDLE_W-1:0] hnd;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] per;
        logic [TIME_W-1:0]   now;
        logic [4:0]          rep;
        logic                typed;
        t_beat               want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [REQ_W-1:0]    i_req_type;
    logic [HANDLE_W-1:0] i_timer_handle;
    logic [SLOT_W-1:0]   i_slot;
    logic [PERIOD_W-1:0] i_period_ms;
    logic [TIME_W-1:0]   i_now_ms;
    logic                o_strobe;
    logic [KIND_W-1:0]   o_kind;
    logic [HANDLE_W-1:0] o_handle;
    logic [SLOT_W-1:0]   o_slot_out;
    logic                o_last;

    // Shadow of the timer table kept by the predictor.
    logic [TIME_W-1:0]   tmr_due   [CAP];
    logic                tmr_dead  [CAP];
    logic [PERIOD_W-1:0] tmr_per   [CAP];
    logic [HANDLE_W-1:0] tmr_owner [CAP];
    int                  tmr_live;

    t_beat expected_beats[$];
    t_beat fresh_beats[$];
    t_row  directed[$];
    int    errors;
    bit    idle_free;

    periodic_timer_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_timer_handle(i_timer_handle),
        .i_slot        (i_slot),
        .i_period_ms   (i_period_ms),
        .i_now_ms      (i_now_ms),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_handle      (o_handle),
        .o_slot_out    (o_slot_out),
        .o_last        (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] due_after(input logic [TIME_W-1:0] t,
                                                     input logic [PERIOD_W-1:0] p);
        logic [TIME_W:0] sum;
        sum = {1'b0, t} + {{(TIME_W+1-PERIOD_W){1'b0}}, p};
        if (sum > {1'b0, TOP_MS})
            return TOP_MS;
        return sum[TIME_W-1:0];
    endfunction

    function automatic void add_row(input t_row row);
        directed = {directed, row};
    endfunction

    function automatic void queue_beat(input t_beat b);
        expected_beats = {expected_beats, b};
    endfunction

    function automatic void add_beat(input t_kind k, input logic [HANDLE_W-1:0] h,
                                     input int s, input logic l);
        t_beat b;
        b.kind = k;
        b.hnd  = h;
        b.slot = s[SLOT_W-1:0];
        b.last = l;
        fresh_beats = {fresh_beats, b};
    endfunction

    // Computes the beats of one accepted request and updates the shadow table.
    function automatic void apply_request(input t_req rq, input logic [HANDLE_W-1:0] h,
                                          input logic [SLOT_W-1:0] s,
                                          input logic [PERIOD_W-1:0] p,
                                          input logic [TIME_W-1:0] now);
        int idx;
        int fill;
        case (rq)
            REQ_START: begin
                if (tmr_live >= CAP) begin
                    add_beat(K_FULL, '0, 0, 1'b1);
                end else begin
                    tmr_due[tmr_live]   = due_after(now, p);
                    tmr_dead[tmr_live]  = 1'b0;
                    tmr_per[tmr_live]   = p;
                    tmr_owner[tmr_live] = h;
                    add_beat(K_ASSIGNED, h, tmr_live, 1'b1);
                    tmr_live++;
                end
            end
            REQ_RESTART, REQ_KILL: begin
                if (int'(s) >= tmr_live) begin
                    add_beat(K_BAD, '0, int'(s), 1'b1);
                end else begin
                    if (rq == REQ_RESTART) begin
                        tmr_due[s]  = due_after(now, p);
                        tmr_dead[s] = 1'b0;
                        tmr_per[s]  = p;
                    end else begin
                        tmr_dead[s] = 1'b1;
                    end
                    add_beat(K_ACK, '0, int'(s), 1'b1);
                end
            end
            default: begin
                idx  = 0;
                fill = tmr_live;
                // A dead entry is replaced by the last one, which is then looked at again.
                while (idx < fill) begin
                    if (tmr_dead[idx]) begin
                        fill--;
                        if (fill != idx) begin
                            tmr_due[idx]   = tmr_due[fill];
                            tmr_dead[idx]  = tmr_dead[fill];
                            tmr_per[idx]   = tmr_per[fill];
                            tmr_owner[idx] = tmr_owner[fill];
                            add_beat(K_RELOC, tmr_owner[idx], idx, 1'b0);
                        end
                    end else begin
                        idx++;
                    end
                end
                tmr_live = fill;
                for (idx = 0; idx < fill; idx++) begin
                    if (now >= tmr_due[idx]) begin
                        tmr_due[idx] = due_after(tmr_due[idx], tmr_per[idx]);
                        add_beat(K_FIRED, tmr_owner[idx], idx, 1'b0);
                    end
                end
                add_beat(K_DONE, '0, 0, 1'b1);
            end
        endcase
    endfunction

    task automatic issue(input t_req rq, input logic [HANDLE_W-1:0] h,
                         input logic [SLOT_W-1:0] s, input logic [PERIOD_W-1:0] p,
                         input logic [TIME_W-1:0] now, input logic typed,
                         input t_beat want);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= rq;
        i_timer_handle <= h;
        i_slot         <= s;
        i_period_ms    <= p;
        i_now_ms       <= now;
        do @(posedge i_clk); while (busy !== 1'b0);
        fresh_beats.delete();
        apply_request(rq, h, s, p, now);
        if (typed)
            queue_beat(want);
        else
            foreach (fresh_beats[k]) queue_beat(fresh_beats[k]);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: kind %0d handle %0h slot %0d",
                       o_kind, o_handle, o_slot_out);
                errors++;
            end else begin
                if (o_kind !== expected_beats[0].kind) begin
                    $error("kind: expected %0d, got %0d", expected_beats[0].kind, o_kind);
                    errors++;
                end
                if (o_handle !== expected_beats[0].hnd) begin
                    $error("handle: expected %0h, got %0h", expected_beats[0].hnd, o_handle);
                    errors++;
                end
                if (o_slot_out !== expected_beats[0].slot) begin
                    $error("slot_out: expected %0d, got %0d", expected_beats[0].slot,
                           o_slot_out);
                    errors++;
                end
                if (o_last !== expected_beats[0].last) begin
                    $error("last: expected %0d, got %0d", expected_beats[0].last, o_last);
                    errors++;
                end
                void'(expected_beats.pop_front());
            end
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row                r;
        t_beat               none;
        t_req                rq;
        logic [HANDLE_W-1:0] h;
        logic [SLOT_W-1:0]   s;
        logic [PERIOD_W-1:0] p;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   clock_ms;
        int                  pick;

        errors         = 0;
        tmr_live       = 0;
        idle_free      = 1'b0;
        none           = '0;
        clock_ms       = '0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_req_type     <= REQ_START;
        i_timer_handle <= '0;
        i_slot         <= '0;
        i_period_ms    <= '0;
        i_now_ms       <= '0;
        for (int k = 0; k < CAP; k++) begin
            tmr_due[k]   = '0;
            tmr_dead[k]  = 1'b0;
            tmr_per[k]   = '0;
            tmr_owner[k] = '0;
        end

        // Directed table: request fields, repeat count, and a typed beat where obvious.
        add_row('{REQ_CHECK, 16'h0, 4'd0, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_DONE, 16'h0, 4'd0, 1'b1}});
        add_row('{REQ_RESTART, 16'h0, 4'd0, 32'd7, 63'd0, 5'd1, 1'b1,
                  '{K_BAD, 16'h0, 4'd0, 1'b1}});
        add_row('{REQ_KILL, 16'h0, 4'd15, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_BAD, 16'h0, 4'd15, 1'b1}});
        add_row('{REQ_START, 16'hFFFF, 4'd0, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_ASSIGNED, 16'hFFFF, 4'd0, 1'b1}});
        add_row('{REQ_START, 16'h0, 4'd15, 32'hFFFF_FFFF, TOP_MS, 5'd1, 1'b1,
                  '{K_ASSIGNED, 16'h0, 4'd1, 1'b1}});
        // Saturated due times fire again on every check at the top of time.
        add_row('{REQ_CHECK, 16'h0, 4'd0, 32'd0, TOP_MS, 5'd1, 1'b0, none});
        add_row('{REQ_CHECK, 16'h0, 4'd0, 32'd0, TOP_MS, 5'd1, 1'b0, none});
        add_row('{REQ_KILL, 16'h0, 4'd1, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_ACK, 16'h0, 4'd1, 1'b1}});
        add_row('{REQ_KILL, 16'h0, 4'd1, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_ACK, 16'h0, 4'd1, 1'b1}});
        add_row('{REQ_RESTART, 16'h0, 4'd1, 32'd5, 63'd100, 5'd1, 1'b1,
                  '{K_ACK, 16'h0, 4'd1, 1'b1}});
        add_row('{REQ_KILL, 16'h0, 4'd1, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_ACK, 16'h0, 4'd1, 1'b1}});
        // Removing the last entry reports no move.
        add_row('{REQ_CHECK, 16'h0, 4'd0, 32'd0, 63'd0, 5'd1, 1'b0, none});
        add_row('{REQ_START, 16'h1000, 4'd0, 32'd10, 63'd1000, 5'd15, 1'b0, none});
        add_row('{REQ_START, 16'hAAAA, 4'd0, 32'd1, 63'd0, 5'd1, 1'b1,
                  '{K_FULL, 16'h0, 4'd0, 1'b1}});
        add_row('{REQ_RESTART, 16'h0, 4'd15, 32'd0, 63'd50, 5'd1, 1'b1,
                  '{K_ACK, 16'h0, 4'd15, 1'b1}});
        // Full table, every entry due: the longest run of beats.
        add_row('{REQ_CHECK, 16'h0, 4'd0, 32'd0, 63'h100_0000_0000, 5'd1, 1'b0, none});
        add_row('{REQ_KILL, 16'h0, 4'd0, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_ACK, 16'h0, 4'd0, 1'b1}});
        add_row('{REQ_KILL, 16'h0, 4'd5, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_ACK, 16'h0, 4'd5, 1'b1}});
        add_row('{REQ_KILL, 16'h0, 4'd15, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_ACK, 16'h0, 4'd15, 1'b1}});
        add_row('{REQ_KILL, 16'h0, 4'd14, 32'd0, 63'd0, 5'd1, 1'b1,
                  '{K_ACK, 16'h0, 4'd14, 1'b1}});
        add_row('{REQ_CHECK, 16'h0, 4'd0, 32'd0, 63'h5555_5555_5555_5555,
                  5'd1, 1'b0, none});
        add_row('{REQ_RESTART, 16'h5555, 4'd13, 32'hFFFF_FFFF,
                  63'h2AAA_AAAA_AAAA_AAAA, 5'd1, 1'b0, none});
        add_row('{REQ_RESTART, 16'h0, 4'd3, 32'hFFFF_FFFF, TOP_MS - 63'd1,
                  5'd1, 1'b0, none});
        add_row('{REQ_CHECK, 16'h0, 4'd0, 32'd0, TOP_MS, 5'd1, 1'b0, none});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[n]) begin
            r = directed[n];
            for (int k = 0; k < int'(r.rep); k++)
                issue(r.rq, r.hnd + k[HANDLE_W-1:0], r.slot, r.per, r.now, r.typed, r.want);
        end

        for (int n = 0; n < 272; n++) begin
            if (n % 40 == 0)
                idle_free = ($urandom_range(0, 3) == 0);
            // Drain the block completely once before carrying on.
            if (n == 150) begin
                start <= 1'b0;
                do @(posedge i_clk); while (expected_beats.size() != 0);
            end

            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                clock_ms = clock_ms + TIME_W'($urandom_range(0, 40));
                now      = clock_ms;
            end else if (pick < 90) begin
                now = TIME_W'({$urandom(), $urandom()});
            end else begin
                now = TOP_MS - TIME_W'($urandom_range(0, 3));
            end
            p = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 120) : $urandom();
            h = HANDLE_W'($urandom_range(0, 65535));

            pick = $urandom_range(0, 99);
            if (pick < 30)
                rq = REQ_START;
            else if (pick < 50)
                rq = REQ_RESTART;
            else if (pick < 70)
                rq = REQ_KILL;
            else
                rq = REQ_CHECK;
            if (tmr_live > 0 && $urandom_range(0, 99) < 85)
                s = SLOT_W'($urandom_range(0, tmr_live - 1));
            else
                s = SLOT_W'($urandom_range(0, 15));

            issue(rq, h, s, p, now, 1'b0, none);
        end

        start <= 1'b0;
        do @(posedge i_clk); while (expected_beats.size() != 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* periodic_timer_table.f */
hdl/ptt_pkg.sv
hdl/ptt_ram.sv
hdl/ptt_ctrl.sv
hdl/ptt_dp.sv
hdl/periodic_timer_table.sv
tb/sv/tb.sv
